FILE: rtl/byte_range_label_map_core_assert.svh
// Assertion macros shared by the byte range label map RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n.
`ifndef BYTE_RANGE_LABEL_MAP_CORE_ASSERT_SVH
`define BYTE_RANGE_LABEL_MAP_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define BRLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BRLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/brlm_pkg.sv
// Shared types and constants for the byte range label map.
// No dependencies.
package brlm_pkg;

    localparam int unsigned POS_W       = 32;
    localparam int unsigned LBL_W       = 8;
    localparam int unsigned IN_TDATA_W  = 104;
    localparam int unsigned OUT_TDATA_W = 72;

    localparam logic KIND_PAINT  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Per-entry results of the shared compare unit.
    typedef struct packed {
        logic             merge_hit;
        logic             look_hit;
        logic             hi_v;
        logic [POS_W-1:0] hi_lo;
        logic [POS_W-1:0] hi_hi;
        logic             lo_v;
        logic [POS_W-1:0] lo_lo;
        logic [POS_W-1:0] lo_hi;
    } t_unit_out;

endpackage

FILE: rtl/byte_range_label_map_core.sv
// Top level of the byte range label map: sequencer, table RAM and shared unit.
// Depends on brlm_pkg, brlm_ram, brlm_unit and byte_range_label_map_core_assert.svh.
//
//  Channel   | Signals                      | Contents
//  s (in)    | i_s_tvalid/o_s_tready        | tuser: kind; tdata: start, length, label, byte_pos
//  m (out)   | o_m_tvalid/i_m_tready        | tuser: found, overflow; tdata: start, length, label
//  cfg       | i_cfg_wr_en/i_cfg_wr_data    | max_span
//
// A paint merges same-label overlaps in a pass over the stored ranges, rebuilds the table
// into the other RAM half in a second pass, then places the new range, swaps halves and
// loads the result; a zero-length paint skips the merge and the placement. A lookup
// reads the stored ranges in turn until a hit, then loads the result. Each transaction
// is accepted in idle. The single RAM read port returns one stored range per read.
// Reset is synchronous and active low; it empties the table and clears max_span.
// o_s_tready is high only while idle; a finished result waits in the output register
// and the next transaction may be accepted meanwhile; loading a result stalls while the
// previous one is still waiting.
`include "byte_range_label_map_core_assert.svh"
module byte_range_label_map_core
    import brlm_pkg::*;
#(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned LABEL_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // range_start, range_length, label, byte_pos
    input  logic [0:0]             i_s_tuser,   // kind
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // hit_start, hit_length, hit_label
    output logic [1:0]             o_m_tuser,   // found, overflow
    input  logic                   i_cfg_wr_en,
    input  logic [POS_W-1:0]       i_cfg_wr_data
);
    localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW  = $clog2(ENTRIES + 1);
    localparam int unsigned RW  = 2 * POS_W + LABEL_BITS;
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_MRG_A, S_MRG_D, S_EMIT_A, S_EMIT_D, S_TAIL, S_LOOK_A, S_LOOK_D, S_DONE
    } t_state;

    t_state               r_state;
    logic [POS_W-1:0]     r_max_span;
    logic                 r_kind;
    logic [POS_W-1:0]     r_s, r_e, r_nb, r_ne, r_pos, r_top;
    logic [LABEL_BITS-1:0] r_tag;
    logic                 r_active, r_new_done, r_phase, r_stop, r_ovf;
    logic [IW-1:0]        r_idx;
    logic [CW-1:0]        r_count, r_wcnt;
    logic                 r_bank;
    logic                 r_found;
    logic [POS_W-1:0]     r_hit_lo, r_hit_hi;
    logic [LABEL_BITS-1:0] r_hit_tag;
    logic                 r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic [1:0]           r_m_user;

    logic [RW-1:0]        rd_data, wr_data;
    logic [POS_W-1:0]     ent_lo, ent_hi;
    logic [LABEL_BITS-1:0] ent_tag, in_tag;
    logic [LABEL_BITS+LBL_W-1:0] tag_wide_in, tag_wide_out;
    logic [POS_W:0]       sum_end;
    logic [POS_W-1:0]     in_start, in_len, in_pos, in_end;
    t_unit_out            u;
    logic                 last_idx;

    logic                 em_req, take_new, piece_v, keep, wr_en, advance;
    logic [POS_W-1:0]     em_lo, em_hi, p_lo, p_hi, diff;
    logic [LABEL_BITS-1:0] em_tag;
    logic [POS_W-1:0]     n_nb, n_ne;

    assign in_start    = i_s_tdata[31:0];
    assign in_len      = i_s_tdata[63:32];
    assign in_pos      = i_s_tdata[103:72];
    assign tag_wide_in = {{LABEL_BITS{1'b0}}, i_s_tdata[71:64]};
    assign in_tag      = tag_wide_in[LABEL_BITS-1:0];
    assign sum_end     = {1'b0, in_start} + {1'b0, in_len};
    assign in_end      = sum_end[POS_W] ? {POS_W{1'b1}} : sum_end[POS_W-1:0];

    assign ent_lo  = rd_data[POS_W-1:0];
    assign ent_hi  = rd_data[2*POS_W-1:POS_W];
    assign ent_tag = rd_data[RW-1:2*POS_W];
    assign last_idx = ((CW'(r_idx) + CW'(1)) == r_count);

    brlm_ram #(.WIDTH(RW), .DEPTH(2 << IW)) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr({~r_bank, r_wcnt[IW-1:0]}),
        .i_wr_data(wr_data),
        .i_rd_addr({r_bank, r_idx}),
        .o_rd_data(rd_data)
    );

    brlm_unit #(.LABEL_BITS(LABEL_BITS)) u_unit (
        .i_ent_lo (ent_lo),
        .i_ent_hi (ent_hi),
        .i_ent_tag(ent_tag),
        .i_start  (r_s),
        .i_end    (r_e),
        .i_nb     (r_nb),
        .i_ne     (r_ne),
        .i_tag    (r_tag),
        .i_pos    (r_pos),
        .i_active (r_active),
        .o_res    (u)
    );

    assign n_nb = (u.merge_hit && ent_lo < r_nb) ? ent_lo : r_nb;
    assign n_ne = (u.merge_hit && ent_hi > r_ne) ? ent_hi : r_ne;

    // Chooses the range written next into the rebuilt table, then applies pruning
    // and the table limit to it.
    always_comb begin
        piece_v  = r_phase ? u.lo_v : u.hi_v;
        p_lo     = r_phase ? u.lo_lo : u.hi_lo;
        p_hi     = r_phase ? u.lo_hi : u.hi_hi;
        take_new = 1'b0;
        em_req   = 1'b0;
        em_lo    = r_nb;
        em_hi    = r_ne;
        em_tag   = r_tag;
        advance  = 1'b1;
        if (r_state == S_EMIT_D) begin
            take_new = piece_v && !r_new_done && (p_lo < r_nb);
            em_req   = piece_v;
            advance  = !take_new;
            if (!take_new) begin
                em_lo  = p_lo;
                em_hi  = p_hi;
                em_tag = ent_tag;
            end
        end else if (r_state == S_TAIL) begin
            em_req = !r_new_done;
        end
        diff  = r_top - em_hi;
        keep  = em_req && !r_stop &&
                ((r_wcnt == '0) || (r_max_span == '0) || (diff <= r_max_span));
        wr_en = keep && (r_wcnt != FULL);
        wr_data = {em_tag, em_hi, em_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_max_span <= '0;
            r_count    <= '0;
            r_bank     <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_span <= i_cfg_wr_data;
            end
            if (r_m_valid && i_m_tready && r_state != S_DONE) begin
                r_m_valid <= 1'b0;
            end
            if (wr_en) begin
                r_wcnt <= r_wcnt + CW'(1);
                if (r_wcnt == '0) begin
                    r_top <= em_hi;
                end
            end
            if (keep && r_wcnt == FULL) begin
                r_ovf <= 1'b1;
            end
            if (em_req && !r_stop && !keep) begin
                r_stop <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind     <= i_s_tuser[0];
                        r_s        <= in_start;
                        r_e        <= in_end;
                        r_nb       <= in_start;
                        r_ne       <= in_end;
                        r_tag      <= in_tag;
                        r_pos      <= in_pos;
                        r_active   <= (in_end > in_start);
                        r_new_done <= !(in_end > in_start);
                        r_idx      <= '0;
                        r_phase    <= 1'b0;
                        r_wcnt     <= '0;
                        r_stop     <= 1'b0;
                        r_ovf      <= 1'b0;
                        r_found    <= 1'b0;
                        r_hit_lo   <= '0;
                        r_hit_hi   <= '0;
                        r_hit_tag  <= '0;
                        if (r_count == '0) begin
                            r_state <= (i_s_tuser[0] == KIND_LOOKUP) ? S_DONE : S_TAIL;
                        end else if (i_s_tuser[0] == KIND_LOOKUP) begin
                            r_state <= S_LOOK_A;
                        end else if (in_end > in_start) begin
                            r_state <= S_MRG_A;
                        end else begin
                            r_state <= S_EMIT_A;
                        end
                    end
                end
                S_MRG_A: r_state <= S_MRG_D;
                S_MRG_D: begin
                    r_nb <= n_nb;
                    r_ne <= n_ne;
                    if (last_idx) begin
                        r_idx   <= '0;
                        r_state <= S_EMIT_A;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_MRG_A;
                    end
                end
                S_EMIT_A: r_state <= S_EMIT_D;
                S_EMIT_D: begin
                    if (take_new) begin
                        r_new_done <= 1'b1;
                    end
                    if (advance) begin
                        if (!r_phase) begin
                            r_phase <= 1'b1;
                        end else begin
                            r_phase <= 1'b0;
                            if (last_idx) begin
                                r_state <= S_TAIL;
                            end else begin
                                r_idx   <= r_idx + IW'(1);
                                r_state <= S_EMIT_A;
                            end
                        end
                    end
                end
                S_TAIL: begin
                    r_new_done <= 1'b1;
                    if (r_new_done) begin
                        r_count <= r_wcnt;
                        r_bank  <= ~r_bank;
                        r_state <= S_DONE;
                    end
                end
                S_LOOK_A: r_state <= S_LOOK_D;
                S_LOOK_D: begin
                    if (u.look_hit) begin
                        r_found   <= 1'b1;
                        r_hit_lo  <= ent_lo;
                        r_hit_hi  <= ent_hi;
                        r_hit_tag <= ent_tag;
                        r_state   <= S_DONE;
                    end else if (last_idx) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_LOOK_A;
                    end
                end
                S_DONE: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {tag_wide_out[LBL_W-1:0], r_hit_hi - r_hit_lo, r_hit_lo};
                        r_m_user  <= {(r_kind == KIND_PAINT) && r_ovf, r_found};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign tag_wide_out = {{LBL_W{1'b0}}, r_hit_tag};
    assign o_s_tready   = (r_state == S_IDLE);
    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = r_m_data;
    assign o_m_tuser    = r_m_user;

    `BRLM_ASSERT_NOW(a_count_max, 1'b1, r_count <= FULL, "table count above capacity")
    `BRLM_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready,
                      "ready stayed high after a transaction was accepted")
    `BRLM_ASSERT_NOW(a_lookup_no_ovf, o_m_tvalid, !(o_m_tuser[0] && o_m_tuser[1]),
                     "result flags both found and overflow")
    `BRLM_ASSERT_NOW(a_write_below_cap, wr_en, r_wcnt < FULL,
                     "table rebuild wrote past capacity")
endmodule

FILE: rtl/brlm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brlm_ram #(
    parameter int unsigned WIDTH = 72,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: rtl/brlm_unit.sv
// Shared compare unit: evaluates one stored range against the current transaction.
// Depends on brlm_pkg.
module brlm_unit
    import brlm_pkg::*;
#(
    parameter int unsigned LABEL_BITS = 8
) (
    input  logic [POS_W-1:0]      i_ent_lo,
    input  logic [POS_W-1:0]      i_ent_hi,
    input  logic [LABEL_BITS-1:0] i_ent_tag,
    input  logic [POS_W-1:0]      i_start,
    input  logic [POS_W-1:0]      i_end,
    input  logic [POS_W-1:0]      i_nb,
    input  logic [POS_W-1:0]      i_ne,
    input  logic [LABEL_BITS-1:0] i_tag,
    input  logic [POS_W-1:0]      i_pos,
    input  logic                  i_active,
    output t_unit_out             o_res
);
    logic same_tag;
    logic apart;

    assign same_tag = (i_ent_tag == i_tag);
    assign apart    = !i_active || (i_ent_hi <= i_nb) || (i_ent_lo >= i_ne);

    always_comb begin
        o_res           = '0;
        o_res.merge_hit = same_tag && (i_ent_hi >= i_start) && (i_ent_lo <= i_end);
        o_res.look_hit  = (i_ent_lo <= i_pos) && (i_ent_hi > i_pos);
        if (apart) begin
            o_res.lo_v  = 1'b1;
            o_res.lo_lo = i_ent_lo;
            o_res.lo_hi = i_ent_hi;
        end else if (!same_tag) begin
            // A range with another label keeps what lies outside the new span.
            o_res.hi_v  = (i_ent_hi > i_ne);
            o_res.hi_lo = i_ne;
            o_res.hi_hi = i_ent_hi;
            o_res.lo_v  = (i_nb > i_ent_lo);
            o_res.lo_lo = i_ent_lo;
            o_res.lo_hi = i_nb;
        end
    end
endmodule

FILE: bench/tb_byte_range_label_map_core.sv
// Self-checking bench for byte_range_label_map_core: directed table, then random paints/lookups.
// Depends on brlm_pkg and the RTL of byte_range_label_map_core; results checked by a local model.
module tb_byte_range_label_map_core;
    import brlm_pkg::*;

    localparam int NUM_RANGES = 16;
    localparam int WORK_MAX   = NUM_RANGES + 3;

    typedef struct {
        bit [31:0] lo;
        bit [31:0] hi;
        bit [7:0]  tag;
    } span_s;

    typedef struct {
        bit        found;
        bit [31:0] start;
        bit [31:0] length;
        bit [7:0]  label;
        bit        ovf;
    } answer_s;

    typedef struct {
        bit        kind;
        bit [31:0] start;
        bit [31:0] length;
        bit [7:0]  label;
        bit [31:0] pos;
        bit        fixed;
        answer_s   ans;
    } row_s;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic [0:0]             i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [1:0]             o_m_tuser;
    logic                   i_cfg_wr_en;
    logic [POS_W-1:0]       i_cfg_wr_data;

    byte_range_label_map_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Local copy of the range table.
    bit [31:0] tbl_lo [NUM_RANGES];
    bit [31:0] tbl_len[NUM_RANGES];
    bit [7:0]  tbl_tag[NUM_RANGES];
    int        tbl_cnt;
    bit [31:0] span_limit;
    span_s     pieces[WORK_MAX];
    int        piece_cnt;

    answer_s   pending_answers[$];
    int        err_cnt;
    bit        hold_on;
    bit        stall_on;
    event      hold_go;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        err_cnt++;
    endtask

    function automatic void add_piece(bit [31:0] lo, bit [31:0] hi, bit [7:0] tag);
        int i;
        if (hi <= lo || piece_cnt >= WORK_MAX) return;
        i = piece_cnt;
        while (i > 0 && pieces[i-1].lo < lo) begin
            pieces[i] = pieces[i-1];
            i--;
        end
        pieces[i].lo = lo;
        pieces[i].hi = hi;
        pieces[i].tag = tag;
        piece_cnt++;
    endfunction

    function automatic bit paint_ranges(bit [31:0] s, bit [31:0] len, bit [7:0] tag);
        bit [32:0] e_wide;
        bit [31:0] e, nb, ne, b, en, top;
        int        keep;
        bit        ovf;
        e_wide = {1'b0, s} + {1'b0, len};
        e = (e_wide > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : e_wide[31:0];
        piece_cnt = 0;
        ovf = 1'b0;
        if (e > s) begin
            nb = s;
            ne = e;
            for (int i = 0; i < tbl_cnt; i++) begin
                b = tbl_lo[i];
                en = b + tbl_len[i];
                if (tbl_tag[i] == tag && en >= s && b <= e) begin
                    if (b < nb) nb = b;
                    if (en > ne) ne = en;
                end
            end
            for (int i = 0; i < tbl_cnt; i++) begin
                b = tbl_lo[i];
                en = b + tbl_len[i];
                if (en <= nb || b >= ne) begin
                    add_piece(b, en, tbl_tag[i]);
                end else if (tbl_tag[i] != tag) begin
                    // A differently labeled range keeps what lies outside the new span.
                    add_piece(b, (en < nb) ? en : nb, tbl_tag[i]);
                    add_piece((b > ne) ? b : ne, en, tbl_tag[i]);
                end
            end
            add_piece(nb, ne, tag);
        end else begin
            for (int i = 0; i < tbl_cnt; i++)
                add_piece(tbl_lo[i], tbl_lo[i] + tbl_len[i], tbl_tag[i]);
        end
        if (span_limit != 0 && piece_cnt > 0) begin
            top = pieces[0].hi;
            keep = 1;
            while (keep < piece_cnt && top - pieces[keep].hi <= span_limit)
                keep++;
            piece_cnt = keep;
        end
        if (piece_cnt > NUM_RANGES) begin
            piece_cnt = NUM_RANGES;
            ovf = 1'b1;
        end
        for (int i = 0; i < piece_cnt; i++) begin
            tbl_lo[i] = pieces[i].lo;
            tbl_len[i] = pieces[i].hi - pieces[i].lo;
            tbl_tag[i] = pieces[i].tag;
        end
        tbl_cnt = piece_cnt;
        return ovf;
    endfunction

    function automatic answer_s apply_item(bit kind, bit [31:0] s, bit [31:0] len,
                                           bit [7:0] tag, bit [31:0] pos);
        answer_s a;
        bit [32:0] en;
        a = '{default: 0};
        if (kind == KIND_PAINT) begin
            a.ovf = paint_ranges(s, len, tag);
        end else begin
            for (int i = 0; i < tbl_cnt; i++) begin
                en = {1'b0, tbl_lo[i]} + {1'b0, tbl_len[i]};
                if (tbl_lo[i] <= pos && en > {1'b0, pos}) begin
                    a.found = 1'b1;
                    a.start = tbl_lo[i];
                    a.length = tbl_len[i];
                    a.label = tbl_tag[i];
                    break;
                end
            end
        end
        return a;
    endfunction

    // Offers one item and waits for its transaction; valid stays high for the next call.
    task automatic send_item(bit kind, bit [31:0] s, bit [31:0] len, bit [7:0] tag,
                             bit [31:0] pos, bit fixed, answer_s fixed_ans);
        answer_s a;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= {pos, tag, len, s};
        do @(posedge i_clk); while (!o_s_tready);
        a = apply_item(kind, s, len, tag, pos);
        pending_answers = {pending_answers, (fixed ? fixed_ans : a)};
    endtask

    task automatic idle_gap(int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained;
        i_s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_span_limit(bit [31:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        span_limit = v;
    endtask

    // Long receiver hold-off, counted in cycles once triggered.
    initial begin
        hold_on = 1'b0;
        forever begin
            @(hold_go);
            @(posedge i_clk);
            hold_on <= 1'b1;
            repeat (300) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    // Output side: checks each result transaction and drives tready.
    always @(posedge i_clk) begin
        answer_s e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[63:0], 64'(0));
            end else begin
                e = pending_answers.pop_front();
                if (o_m_tuser[0] !== e.found)
                    report_mismatch("found", 64'(o_m_tuser[0]), 64'(e.found));
                if (o_m_tuser[1] !== e.ovf)
                    report_mismatch("overflow", 64'(o_m_tuser[1]), 64'(e.ovf));
                if (o_m_tdata[31:0] !== e.start)
                    report_mismatch("hit_start", 64'(o_m_tdata[31:0]), 64'(e.start));
                if (o_m_tdata[63:32] !== e.length)
                    report_mismatch("hit_length", 64'(o_m_tdata[63:32]), 64'(e.length));
                if (o_m_tdata[71:64] !== e.label)
                    report_mismatch("hit_label", 64'(o_m_tdata[71:64]), 64'(e.label));
            end
        end
        if (hold_on) begin
            i_m_tready <= 1'b0;
        end else if (stall_on) begin
            i_m_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        row_s      rows[$];
        answer_s   none;
        bit [31:0] limits[5];
        bit [31:0] base;
        bit        kind;
        bit [31:0] s, len, pos;
        bit [7:0]  tag;
        int        burst;

        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        err_cnt = 0;
        stall_on = 1'b0;
        tbl_cnt = 0;
        span_limit = 0;
        none = '{default: 0};

        // kind, start, length, label, pos, fixed, answer
        rows = '{
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'h0, 1, none},
            '{KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1, none},
            '{KIND_PAINT, 32'h0, 32'h0, 8'hFF, 32'hFFFF_FFFF, 1, none},
            '{KIND_PAINT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'hAA, 32'h0, 1, none},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'hFFFF_FFFE, 1,
              '{1, 32'hFFFF_FFF0, 32'hF, 8'hAA, 0}},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'hFFFF_FFFF, 1, none},
            '{KIND_PAINT, 32'h0, 32'd100, 8'h1, 32'h0, 1, none},
            '{KIND_PAINT, 32'd100, 32'd50, 8'h1, 32'h0, 0, none},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'd120, 1, '{1, 32'h0, 32'd150, 8'h1, 0}},
            '{KIND_PAINT, 32'd50, 32'd10, 8'h2, 32'h0, 0, none},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'd55, 0, none},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'd70, 0, none},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'd10, 0, none},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'd150, 0, none},
            '{KIND_PAINT, 32'd40, 32'd200, 8'h1, 32'h0, 0, none},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'd55, 0, none},
            '{KIND_PAINT, 32'h0, 32'hFFFF_FFFF, 8'h0, 32'hFFFF_FFFF, 0, none},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'h8000_0000, 0, none},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'hFFFF_FFF5, 0, none},
            '{KIND_PAINT, 32'h1234_5678, 32'h10, 8'h55, 32'h0, 0, none},
            '{KIND_LOOKUP, 32'h0, 32'h0, 8'h0, 32'h1234_5680, 0, none}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_item(rows[i].kind, rows[i].start, rows[i].length, rows[i].label,
                      rows[i].pos, rows[i].fixed, rows[i].ans);
        wait_drained();

        limits = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'd2000, $urandom};
        for (int ph = 0; ph < 5; ph++) begin
            write_span_limit(limits[ph]);
            stall_on = (ph % 2 == 1);
            base = (ph == 3) ? 32'hFFFF_F000 : $urandom & 32'hFFF0_0000;
            burst = 0;
            for (int n = 0; n < 330; n++) begin
                if (ph == 2 && n == 40) -> hold_go;
                if (n == 150) wait_drained();
                kind = ($urandom_range(0, 2) == 0) ? KIND_LOOKUP : KIND_PAINT;
                s = $urandom;
                len = $urandom;
                pos = $urandom;
                tag = 8'($urandom);
                if ($urandom_range(0, 9) != 0) begin
                    // Most items share a small window so ranges interact and the table fills.
                    s = base + $urandom_range(0, 4095);
                    len = $urandom_range(0, 300);
                    pos = base + $urandom_range(0, 4500);
                    if ($urandom_range(0, 3) != 0) tag = 8'($urandom_range(0, 5));
                end
                send_item(kind, s, len, tag, pos, 0, none);
                if (burst > 0) begin
                    burst--;
                end else begin
                    burst = $urandom_range(0, 12);
                    if (ph != 0) idle_gap($urandom_range(1, 20));
                end
            end
            wait_drained();
        end

        stall_on = 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/brlm_pkg.sv
rtl/brlm_ram.sv
rtl/brlm_unit.sv
rtl/byte_range_label_map_core.sv
bench/tb_byte_range_label_map_core.sv
